>>> rtl/transposition_table_engine_macros.svh
// assertion macros shared by the transposition table checker
`ifndef TRANSPOSITION_TABLE_ENGINE_MACROS_SVH
`define TRANSPOSITION_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk_i and off during reset
`define TTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tte_pkg.sv
// shared types and constants of the transposition table engine
package tte_pkg;

  parameter int SCORE_INF = 32000;
  parameter int MATE      = 30000;

  typedef enum logic [0:0] {
    FUNC_PROBE = 1'b0,
    FUNC_STORE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    BOUND_NONE  = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_EXACT = 2'd3
  } bound_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [63:0]        key;
    logic [6:0]         ply;
    logic [6:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score;
    logic [31:0]        move_code;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               cutoff;
    logic signed [15:0] found_score;
    logic [31:0]        found_move;
    logic [6:0]         found_depth;
    bound_e             found_bound;
  } rsp_t;

  // one way of a set as held in the set memory
  typedef struct packed {
    logic [63:0]        key;
    logic [31:0]        move_code;
    logic [7:0]         age;
    bound_e             bound;
    logic [6:0]         depth;
    logic signed [15:0] score;
  } way_t;

endpackage

>>> rtl/tte_req_if.sv
// request channel: valid, ready and request payload
interface tte_req_if import tte_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/tte_rsp_if.sv
// response channel: valid, ready and response payload
interface tte_rsp_if import tte_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/transposition_table_engine.sv
// Set-associative transposition table. Each transaction is a probe or a store and yields
// exactly one response (all zero for a store or a probe miss). The accepting cycle reads
// its set from the set memory; the exec state matches ways, picks the victim and, once
// the response register is free, writes back the set of a store not skipped. One
// transaction is in flight at a time; the response register lets the next request in while
// a response waits. After reset all 2**INDEX_BITS sets (4096 by default) are cleared,
// one set per cycle with request ready low; current_age writes are taken at any time.
module transposition_table_engine import tte_pkg::*; #(
  parameter int INDEX_BITS = 12,
  parameter int WAYS       = 3,
  parameter int MAX_PLY    = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tte_req_if.sink    req_i,
  tte_rsp_if.source  rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int SETS   = 1 << INDEX_BITS;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = 15;

  localparam logic signed [17:0] MATE_EDGE = 18'(MATE - MAX_PLY);
  localparam logic signed [17:0] MATE_NEG  = 18'(MAX_PLY - MATE);
  localparam logic signed [17:0] SCORE_HI  = 18'(SCORE_INF);
  localparam logic signed [17:0] SCORE_LO  = 18'(-SCORE_INF);

  state_e state_q, state_d;
  logic [INDEX_BITS-1:0] clr_idx_q, clr_idx_d;
  logic [7:0] age_q, age_d;
  req_t req_q;
  way_t [WAYS-1:0] set_q;
  way_t [WAYS-1:0] mem_q [SETS];
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  logic req_accept;
  logic rsp_free;
  logic rsp_load;
  logic mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  way_t [WAYS-1:0] mem_wdata;

  logic hit;
  logic [WAY_W-1:0] hit_idx;
  logic victim_free;
  logic [WAY_W-1:0] free_idx;
  logic [WAY_W-1:0] age_idx;
  logic [RANK_W-1:0] best_rank;
  logic [WAY_W-1:0] victim_idx;
  way_t hit_way;
  way_t new_way;
  way_t [WAYS-1:0] new_set;
  logic store_skip;

  logic signed [17:0] ply_s;
  logic signed [17:0] hit_s;
  logic signed [17:0] found_s;
  logic signed [17:0] st_s;
  logic signed [17:0] st_adj;
  logic signed [17:0] st_clamp;
  logic cut;
  bound_e st_bound;

  assign req_accept = req_i.valid && req_i.ready;
  assign rsp_free   = !rsp_valid_q || rsp_o.ready;

  // way match and victim choice over the set just read
  always_comb begin
    logic [RANK_W-1:0] rank;
    hit         = 1'b0;
    hit_idx     = '0;
    victim_free = 1'b0;
    free_idx    = '0;
    age_idx     = '0;
    best_rank   = '0;
    rank        = '0;
    // walk down so the lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (set_q[w].bound != BOUND_NONE && set_q[w].key == req_q.key) begin
        hit     = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (set_q[w].bound == BOUND_NONE || set_q[w].key == req_q.key) begin
        victim_free = 1'b1;
        free_idx    = WAY_W'(w);
      end
    end
    // age * 256 - depth orders the same as {age, ~depth}
    for (int w = 0; w < WAYS; w++) begin
      rank = {8'(age_q - set_q[w].age), ~set_q[w].depth};
      if (w == 0 || rank > best_rank) begin
        best_rank = rank;
        age_idx   = WAY_W'(w);
      end
    end
  end

  assign victim_idx = victim_free ? free_idx : age_idx;
  assign hit_way    = set_q[hit_idx];
  assign ply_s      = signed'({11'd0, req_q.ply});
  assign hit_s      = 18'(hit_way.score);
  assign st_s       = 18'(req_q.score);

  // probe: undo the mate distance and test the bound
  always_comb begin
    if (hit_s >= MATE_EDGE) begin
      found_s = hit_s - ply_s;
    end else if (hit_s <= MATE_NEG) begin
      found_s = hit_s + ply_s;
    end else begin
      found_s = hit_s;
    end
    cut = 1'b0;
    if (hit_way.depth >= req_q.depth) begin
      case (hit_way.bound)
        BOUND_EXACT: cut = 1'b1;
        BOUND_LOWER: cut = (found_s >= 18'(req_q.beta));
        BOUND_UPPER: cut = (found_s <= 18'(req_q.alpha));
        default:     cut = 1'b0;
      endcase
    end
  end

  // store: mate distance from the root, clamp, bound from the window
  always_comb begin
    if (st_s >= MATE_EDGE) begin
      st_adj = st_s + ply_s;
    end else if (st_s <= MATE_NEG) begin
      st_adj = st_s - ply_s;
    end else begin
      st_adj = st_s;
    end
    if (st_adj > SCORE_HI) begin
      st_clamp = SCORE_HI;
    end else if (st_adj < SCORE_LO) begin
      st_clamp = SCORE_LO;
    end else begin
      st_clamp = st_adj;
    end
    if (req_q.score <= req_q.alpha) begin
      st_bound = BOUND_UPPER;
    end else if (req_q.score >= req_q.beta) begin
      st_bound = BOUND_LOWER;
    end else begin
      st_bound = BOUND_EXACT;
    end
  end

  always_comb begin
    new_way.key       = req_q.key;
    new_way.move_code = req_q.move_code;
    new_way.age       = age_q;
    new_way.bound     = st_bound;
    new_way.depth     = req_q.depth;
    new_way.score     = 16'(st_clamp);
    new_set           = set_q;
    new_set[victim_idx] = new_way;
  end

  assign store_skip = hit && (req_q.depth < hit_way.depth) && (hit_way.age == age_q);

  always_comb begin
    rsp_d = '0;
    if (req_q.func == FUNC_PROBE && hit) begin
      rsp_d.hit         = 1'b1;
      rsp_d.cutoff      = cut;
      rsp_d.found_score = 16'(found_s);
      rsp_d.found_move  = hit_way.move_code;
      rsp_d.found_depth = hit_way.depth;
      rsp_d.found_bound = hit_way.bound;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = req_q.key[INDEX_BITS-1:0];
    mem_wdata   = new_set;
    rsp_load    = 1'b0;
    clr_idx_d   = clr_idx_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        clr_idx_d = clr_idx_q + 1'b1;
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      ST_EXEC: begin
        rsp_load = rsp_free;
        mem_we   = rsp_free && (req_q.func == FUNC_STORE) && !store_skip;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign age_d = cfg_we_i ? cfg_wdata_i : age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      age_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      age_q       <= age_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      req_q <= req_i.payload;
    end
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  // set memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (req_accept) begin
      set_q <= mem_q[req_i.payload.key[INDEX_BITS-1:0]];
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

>>> rtl/tte_checker.sv
// port-level checker for the transposition table engine, bound to the top level
`include "transposition_table_engine_macros.svh"

module tte_checker import tte_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  tte_req_if.sink   req_i,
  tte_rsp_if.source rsp_o
);

  // one transaction in flight
  `TTE_ASSERT_NEXT(a_one_in_flight, req_i.valid && req_i.ready, !req_i.ready, "request accepted while busy")

  `TTE_ASSERT_NEXT(a_rsp_hold, rsp_o.valid && !rsp_o.ready, rsp_o.valid && $stable(rsp_o.payload), "stalled response changed")

  `TTE_ASSERT_IMP(a_cut_needs_hit, rsp_o.valid && rsp_o.payload.cutoff, rsp_o.payload.hit, "cutoff without hit")

  `TTE_ASSERT_IMP(a_miss_zero, rsp_o.valid && !rsp_o.payload.hit, rsp_o.payload.found_score == 16'sd0 && rsp_o.payload.found_move == 32'd0 && rsp_o.payload.found_depth == 7'd0 && rsp_o.payload.found_bound == BOUND_NONE, "miss response not zero")

  `TTE_ASSERT_IMP(a_hit_bound, rsp_o.valid && rsp_o.payload.hit, rsp_o.payload.found_bound != BOUND_NONE, "hit on a free way")

endmodule

bind transposition_table_engine tte_checker u_tte_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

>>> test/tb_transposition_table_engine.sv
// testbench for the transposition table engine: directed and random probes and stores
module tb_transposition_table_engine import tte_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS        = 4096;
  localparam int NWAYS       = 3;
  localparam int MATE_EDGE   = MATE - 128;
  localparam int HOLD_CYCLES = 300;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic       rx_rdy      = 1'b0;
  logic       rx_hold     = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int err_cnt     = 0;
  int n_sent      = 0;
  int n_probe     = 0;
  int n_hit       = 0;
  int n_cut       = 0;
  int n_skip      = 0;
  int n_evict     = 0;
  int n_age       = 0;

  event stall_kick;

  // behavioral copy of the table and of current_age
  logic [63:0]        tt_key   [SETS*NWAYS];
  logic [31:0]        tt_move  [SETS*NWAYS];
  logic signed [15:0] tt_score [SETS*NWAYS];
  logic [6:0]         tt_depth [SETS*NWAYS];
  bound_e             tt_bound [SETS*NWAYS];
  logic [7:0]         tt_age   [SETS*NWAYS];
  logic [7:0]         table_age;

  rsp_t pending_rsp_q [$];

  logic [51:0] tag_pool [6];
  logic [11:0] set_pool [8] = '{12'h000, 12'h001, 12'hfff, 12'h800,
                                12'h04d, 12'h4d2, 12'hbb8, 12'h555};

  tte_req_if req_bus ();
  tte_rsp_if rsp_bus ();

  assign rsp_bus.ready = rx_rdy;

  always #2 clk_i = ~clk_i;

  transposition_table_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  function automatic rsp_t predict_table_access(req_t r);
    rsp_t       o;
    int         base, hit_at, vict, s, sc, pl, al, be, v, best_val;
    logic [7:0] age_gap;
    logic       cut;
    bound_e     bd;
    o      = '0;
    base   = int'(r.key[11:0]) * NWAYS;
    pl     = int'(r.ply);
    al     = int'($signed(r.alpha));
    be     = int'($signed(r.beta));
    sc     = int'($signed(r.score));
    hit_at = -1;
    for (int w = 0; w < NWAYS; w++)
      if (hit_at < 0 && tt_bound[base + w] != BOUND_NONE && tt_key[base + w] == r.key)
        hit_at = base + w;

    if (r.func == FUNC_PROBE) begin
      n_probe++;
      if (hit_at >= 0) begin
        n_hit++;
        s = int'(tt_score[hit_at]);
        if (s >= MATE_EDGE) s = s - pl;
        else if (s <= -MATE_EDGE) s = s + pl;
        cut = 1'b0;
        if (tt_depth[hit_at] >= r.depth) begin
          if (tt_bound[hit_at] == BOUND_EXACT) cut = 1'b1;
          else if (tt_bound[hit_at] == BOUND_LOWER && s >= be) cut = 1'b1;
          else if (tt_bound[hit_at] == BOUND_UPPER && s <= al) cut = 1'b1;
        end
        if (cut) n_cut++;
        o.hit         = 1'b1;
        o.cutoff      = cut;
        o.found_score = s[15:0];
        o.found_move  = tt_move[hit_at];
        o.found_depth = tt_depth[hit_at];
        o.found_bound = tt_bound[hit_at];
      end
      return o;
    end

    // a deeper entry of this generation is kept
    if (hit_at >= 0 && r.depth < tt_depth[hit_at] && tt_age[hit_at] == table_age) begin
      n_skip++;
      return o;
    end
    vict = -1;
    for (int w = 0; w < NWAYS; w++)
      if (vict < 0 && (tt_bound[base + w] == BOUND_NONE || tt_key[base + w] == r.key))
        vict = base + w;
    if (vict < 0) begin
      n_evict++;
      best_val = 0;
      for (int w = 0; w < NWAYS; w++) begin
        age_gap = table_age - tt_age[base + w];
        v = int'(age_gap) * 256 - int'(tt_depth[base + w]);
        if (w == 0 || v > best_val) begin
          best_val = v;
          vict     = base + w;
        end
      end
    end
    if (sc <= al) bd = BOUND_UPPER;
    else if (sc >= be) bd = BOUND_LOWER;
    else bd = BOUND_EXACT;
    s = sc;
    if (s >= MATE_EDGE) s = s + pl;
    else if (s <= -MATE_EDGE) s = s - pl;
    if (s > SCORE_INF) s = SCORE_INF;
    if (s < -SCORE_INF) s = -SCORE_INF;
    tt_key[vict]   = r.key;
    tt_move[vict]  = r.move_code;
    tt_score[vict] = s[15:0];
    tt_depth[vict] = r.depth;
    tt_bound[vict] = bd;
    tt_age[vict]   = table_age;
    return o;
  endfunction

  function automatic req_t make_request(func_e f, logic [63:0] k, logic [6:0] pl,
                                        logic [6:0] d, logic signed [15:0] a,
                                        logic signed [15:0] b, logic signed [15:0] sc,
                                        logic [31:0] mv);
    req_t r;
    r.func      = f;
    r.key       = k;
    r.ply       = pl;
    r.depth     = d;
    r.alpha     = a;
    r.beta      = b;
    r.score     = sc;
    r.move_code = mv;
    return r;
  endfunction

  function automatic int rand_score();
    int                 pick;
    logic signed [15:0] raw;
    pick = $urandom_range(0, 19);
    raw  = $urandom;
    if (pick < 12) return int'($urandom_range(0, 2000)) - 1000;
    if (pick < 15) return int'($urandom_range(29800, 32000));
    if (pick < 18) return -int'($urandom_range(29800, 32000));
    if (pick == 18) return int'($urandom_range(0, 64000)) - 32000;
    return int'(raw);
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 7)]};
  endfunction

  function automatic req_t rand_request(logic [63:0] k, func_e f);
    int sc, al, be, d;
    sc = rand_score();
    al = sc + int'($urandom_range(0, 80)) - 40;
    be = al + int'($urandom_range(1, 80));
    d  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
    return make_request(f, k, 7'($urandom_range(0, 127)), d[6:0], al[15:0], be[15:0],
                        sc[15:0], $urandom);
  endfunction

  // one request transaction; valid stays high when the next one follows at once
  task automatic send_item(req_t r);
    int gap;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.payload <= r;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    pending_rsp_q = {pending_rsp_q, predict_table_access(r)};
    n_sent++;
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_age(logic [7:0] a);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    table_age  = a;
    n_age++;
  endtask

  task automatic test_directed();
    tx_idle_pct = 18;
    rx_idle_pct = 70;
    // empty table, then a fresh exact entry
    send_item(make_request(FUNC_PROBE, 64'h0, 0, 0, 0, 0, 0, 0));
    send_item(make_request(FUNC_STORE, 64'h0, 0, 5, -100, 100, 10, 32'h1));
    send_item(make_request(FUNC_PROBE, 64'h0, 0, 5, 0, 0, 0, 0));
    send_item(make_request(FUNC_PROBE, 64'h0, 0, 6, 0, 0, 0, 0));
    // shallower store over a deeper entry of this generation
    send_item(make_request(FUNC_STORE, 64'h0, 0, 3, -100, 100, 20, 32'h2));
    send_item(make_request(FUNC_PROBE, 64'h0, 0, 0, 0, 0, 0, 0));
    // widest fields, mate score clamped
    send_item(make_request(FUNC_STORE, '1, 127, 127, -32001, 32001, 32000, '1));
    send_item(make_request(FUNC_PROBE, '1, 127, 127, 0, 0, 0, 0));
    // upper and lower bounds, with and without cutoff
    send_item(make_request(FUNC_STORE, 64'h1234_5678_9abc_d000, 10, 4, 50, 100, 50, 32'h3));
    send_item(make_request(FUNC_PROBE, 64'h1234_5678_9abc_d000, 0, 4, 60, 70, 0, 0));
    send_item(make_request(FUNC_PROBE, 64'h1234_5678_9abc_d000, 0, 4, 40, 70, 0, 0));
    send_item(make_request(FUNC_STORE, 64'hdead_beef_0000_0000, 0, 2, 0, 400, 500, 32'h4));
    send_item(make_request(FUNC_PROBE, 64'hdead_beef_0000_0000, 0, 0, 0, 500, 0, 0));
    send_item(make_request(FUNC_PROBE, 64'hdead_beef_0000_0000, 0, 0, 0, 501, 0, 0));
    // full set forces an eviction, negative mate score
    send_item(make_request(FUNC_STORE, 64'h0f0f_0f0f_0f0f_0000, 100, 1, -32001, 32001,
                           -30000, 32'h5));
    send_item(make_request(FUNC_PROBE, 64'h0f0f_0f0f_0f0f_0000, 100, 0, 0, 0, 0, 0));
    send_item(make_request(FUNC_PROBE, 64'hdead_beef_0000_0000, 0, 0, 0, 0, 0, 0));
    send_item(make_request(FUNC_STORE, 64'h0, 0, 9, -32000, 0, -32000, 32'h6));
    send_item(make_request(FUNC_PROBE, 64'h0, 127, 0, -32001, 0, 0, 0));
    // scores outside the nominal range
    send_item(make_request(FUNC_STORE, 64'h5555_aaaa_5555_a001, 5, 0, 16'sh7fff, 16'sh8000,
                           16'sh8000, 32'haaaa_5555));
    send_item(make_request(FUNC_PROBE, 64'h5555_aaaa_5555_a001, 0, 0, 16'sh7fff, 0, 0, 0));
    send_item(make_request(FUNC_STORE, 64'haaaa_5555_aaaa_5ffe, 3, 7, 32000, -32000,
                           16'sh7fff, 32'h5555_aaaa));
    send_item(make_request(FUNC_PROBE, 64'haaaa_5555_aaaa_5ffe, 0, 0, 0, 16'sh7fff, 0, 0));
  endtask

  task automatic test_random(int n_items, int tx_pct, int rx_pct);
    int          sent;
    logic [63:0] k;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent        = 0;
    while (sent < n_items) begin
      k = pick_key();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // store followed by a probe of the same position
          send_item(rand_request(k, FUNC_STORE));
          send_item(rand_request(k, FUNC_PROBE));
          sent += 2;
        end
        4, 5, 6: begin
          send_item(rand_request(k, FUNC_PROBE));
          sent++;
        end
        default: begin
          send_item(rand_request(k, FUNC_STORE));
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    -> stall_kick;
    repeat (40) send_item(rand_request(pick_key(), func_e'($urandom_range(0, 1))));
    // sender pauses until every response is back
    wait_idle();
    repeat (10) send_item(rand_request(pick_key(), func_e'($urandom_range(0, 1))));
  endtask

  // long receiver hold-off
  always begin
    @(stall_kick);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    rx_rdy <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin : check_rsp
    rsp_t want;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        $error("response transaction with none pending");
        err_cnt++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_bus.payload.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp_bus.payload.hit);
          err_cnt++;
        end
        if (rsp_bus.payload.cutoff !== want.cutoff) begin
          $error("cutoff: expected %0d, got %0d", want.cutoff, rsp_bus.payload.cutoff);
          err_cnt++;
        end
        if (rsp_bus.payload.found_score !== want.found_score) begin
          $error("found_score: expected %0d, got %0d", want.found_score,
                 rsp_bus.payload.found_score);
          err_cnt++;
        end
        if (rsp_bus.payload.found_move !== want.found_move) begin
          $error("found_move: expected %h, got %h", want.found_move,
                 rsp_bus.payload.found_move);
          err_cnt++;
        end
        if (rsp_bus.payload.found_depth !== want.found_depth) begin
          $error("found_depth: expected %0d, got %0d", want.found_depth,
                 rsp_bus.payload.found_depth);
          err_cnt++;
        end
        if (rsp_bus.payload.found_bound !== want.found_bound) begin
          $error("found_bound: expected %0d, got %0d", want.found_bound,
                 rsp_bus.payload.found_bound);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    req_bus.valid   <= 1'b0;
    req_bus.payload <= '0;
    foreach (tt_bound[i]) begin
      tt_key[i]   = '0;
      tt_move[i]  = '0;
      tt_score[i] = '0;
      tt_depth[i] = '0;
      tt_bound[i] = BOUND_NONE;
      tt_age[i]   = '0;
    end
    table_age   = '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = {$urandom, $urandom};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    write_age(8'd1);
    test_random(500, 18, 70);
    write_age(8'd255);
    test_random(500, 70, 18);
    write_age(8'd0);
    test_backpressure();
    write_age(8'd128);
    test_random(520, 0, 0);
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("covered %0d transactions: %0d probes, %0d hits, %0d cutoffs",
             n_sent, n_probe, n_hit, n_cut);
    $display("%0d stores kept a deeper entry, %0d evictions, %0d age writes",
             n_skip, n_evict, n_age);
    if (err_cnt == 0) begin
      $display("tb_transposition_table_engine: done, clean");
    end else begin
      $display("tb_transposition_table_engine: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_transposition_table_engine: done, errors");
    $finish;
  end

endmodule

>>> transposition_table_engine.f
+incdir+rtl
rtl/tte_pkg.sv
rtl/tte_req_if.sv
rtl/tte_rsp_if.sv
rtl/transposition_table_engine.sv
rtl/tte_checker.sv
test/tb_transposition_table_engine.sv
